/* rtl/dmn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_pkg - shared definitions for the debounced menu navigator
// Button bit positions, field widths, parameter defaults and the result type.
// ----------------------------------------------------------------------------
package dmn_pkg;

  // Fixed field widths
  localparam int RawW  = 9;   // raw_levels / buttons_down
  localparam int IdxW  = 8;   // menu_count, selected_index, window_offset
  localparam int MaxButtons = 16;

  // Parameter defaults
  localparam int NumButtonsDef  = 9;
  localparam int VisibleRowsDef = 4;
  localparam int HistoryBitsDef = 8;

  // Reset value of the menu count register
  localparam logic [IdxW-1:0] MenuCountRst = 8'd1;

  // Button positions in the level vector
  localparam int BtnOk     = 0;
  localparam int BtnCancel = 1;
  localparam int BtnZPlus  = 6;
  localparam int BtnZMinus = 7;

  // One result item
  typedef struct packed {
    logic [RawW-1:0] buttons_down;
    logic            select_event;
    logic            cancel_event;
    logic [IdxW-1:0] selected_index;
    logic [IdxW-1:0] window_offset;
    logic            redraw;
    logic            beep;
  } result_t;

endpackage

/* rtl/dmn_debounce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_debounce - shift register debouncer bank
// Each button shifts its raw level into a history; all ones releases, all
// zeros presses, anything else holds. Next state is shown combinationally and
// committed on update_i.
// ----------------------------------------------------------------------------
module dmn_debounce #(
  parameter int NUM_BUTTONS  = dmn_pkg::NumButtonsDef,
  parameter int HISTORY_BITS = dmn_pkg::HistoryBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   update_i,
  input  logic [NUM_BUTTONS-1:0] raw_i,
  output logic [NUM_BUTTONS-1:0] pressed_o,
  output logic [NUM_BUTTONS-1:0] toggled_o
);

  logic [HISTORY_BITS-1:0] hist_q [NUM_BUTTONS];
  logic [HISTORY_BITS-1:0] hist_d [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]  pressed_q, pressed_d;

  // Shift in the new sample and classify each history
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hist_d[i] = {hist_q[i][HISTORY_BITS-2:0], raw_i[i]};
      if (&hist_d[i]) begin
        pressed_d[i] = 1'b0;
      end else if (~|hist_d[i]) begin
        pressed_d[i] = 1'b1;
      end else begin
        pressed_d[i] = pressed_q[i];
      end
    end
  end

  assign pressed_o = pressed_d;
  assign toggled_o = pressed_d ^ pressed_q;

  // History and debounced state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hist_q[i] <= '1;
      end
      pressed_q <= '0;
    end else if (update_i) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hist_q[i] <= hist_d[i];
      end
      pressed_q <= pressed_d;
    end
  end

endmodule

/* rtl/debounced_menu_navigator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_menu_navigator_core - button debouncer and menu cursor
// Debounces nine active-low buttons, consumes one press per item and moves a
// clamped selection with a scrolling row window.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+----------------------------------------
//  in      | in_valid_i/in_ready_o | raw_levels_i
//  out     | out_valid_o/out_ready_i | buttons_down_o, select_event_o,
//          |                       | cancel_event_o, selected_index_o,
//          |                       | window_offset_o, redraw_o, beep_o
//  cfg     | cfg_we_i              | cfg_wdata_i (menu_count)
//
// One item per cycle sustained while out_ready_i is high. The input register
// takes the accepted item; the result register then loads, raising out_valid_o.
// All state updates happen in the single pass between those two registers.
// Reset puts every history at released, clears flags, selection and window,
// and sets menu_count to 1; there is no clearing pass. An output stall holds
// the result, one more item waits in the input register, then in_ready_o drops.
// ----------------------------------------------------------------------------
module debounced_menu_navigator_core #(
  parameter int NUM_BUTTONS  = dmn_pkg::NumButtonsDef,
  parameter int VISIBLE_ROWS = dmn_pkg::VisibleRowsDef,
  parameter int HISTORY_BITS = dmn_pkg::HistoryBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [dmn_pkg::IdxW-1:0]    cfg_wdata_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dmn_pkg::RawW-1:0]    raw_levels_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dmn_pkg::RawW-1:0]    buttons_down_o,
  output logic                        select_event_o,
  output logic                        cancel_event_o,
  output logic [dmn_pkg::IdxW-1:0]    selected_index_o,
  output logic [dmn_pkg::IdxW-1:0]    window_offset_o,
  output logic                        redraw_o,
  output logic                        beep_o
);

  localparam int IdxW = dmn_pkg::IdxW;
  localparam int MaxB = dmn_pkg::MaxButtons;
  localparam int SumW = $clog2((1 << IdxW) + VISIBLE_ROWS);

  // Handshake and stage control
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  logic in_fire;

  logic [dmn_pkg::RawW-1:0] raw_q;
  logic [IdxW-1:0]          menu_q;

  logic [NUM_BUTTONS-1:0] changed_q, changed_d;
  logic [IdxW-1:0]        sel_q, sel_d;
  logic [IdxW-1:0]        win_q, win_d;

  dmn_pkg::result_t res_q, res_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Debouncer bank
  logic [MaxB-1:0]        raw_pad;
  logic [NUM_BUTTONS-1:0] pressed_n, toggled_n;

  assign raw_pad = MaxB'(raw_q);

  dmn_debounce #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .HISTORY_BITS(HISTORY_BITS)
  ) u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (s1_adv),
    .raw_i    (raw_pad[NUM_BUTTONS-1:0]),
    .pressed_o(pressed_n),
    .toggled_o(toggled_n)
  );

  // Press consumption, selection clamp and window follow
  logic [MaxB-1:0]  press_pad;
  logic [MaxB-1:0]  taken;
  logic             take_ok, take_cancel, take_zm, take_zp;
  logic [IdxW:0]    sel_w, count_w;
  logic             beep;
  logic [IdxW-1:0]  win_base;
  logic [SumW-1:0]  win_lim;
  logic             win_move;

  always_comb begin
    press_pad = MaxB'(pressed_n & (changed_q | toggled_n));

    take_ok     = press_pad[dmn_pkg::BtnOk];
    take_cancel = !take_ok && press_pad[dmn_pkg::BtnCancel];
    take_zm     = !take_ok && !take_cancel && press_pad[dmn_pkg::BtnZMinus];
    take_zp     = !take_ok && !take_cancel && !take_zm && press_pad[dmn_pkg::BtnZPlus];

    taken = '0;
    taken[dmn_pkg::BtnOk]     = take_ok;
    taken[dmn_pkg::BtnCancel] = take_cancel;
    taken[dmn_pkg::BtnZMinus] = take_zm;
    taken[dmn_pkg::BtnZPlus]  = take_zp;
    changed_d = (changed_q | toggled_n) & ~taken[NUM_BUTTONS-1:0];

    // candidate selection, low end clamped here
    beep = 1'b0;
    if (take_cancel) begin
      sel_w = '0;
    end else if (take_zm) begin
      sel_w = {1'b0, sel_q} + (IdxW+1)'(1);
    end else if (take_zp) begin
      if (sel_q == '0) begin
        sel_w = '0;
        beep  = 1'b1;
      end else begin
        sel_w = {1'b0, sel_q} - (IdxW+1)'(1);
      end
    end else begin
      sel_w = {1'b0, sel_q};
    end

    // high end: a zero count behaves as one
    count_w = (menu_q == '0) ? (IdxW+1)'(1) : {1'b0, menu_q};
    if (sel_w >= count_w) begin
      sel_w = count_w - (IdxW+1)'(1);
      beep  = 1'b1;
    end
    sel_d = sel_w[IdxW-1:0];

    // window moves at most one row per item
    win_base = take_cancel ? '0 : win_q;
    win_lim  = SumW'(win_base) + SumW'(VISIBLE_ROWS);
    win_move = 1'b1;
    if (SumW'(sel_d) >= win_lim) begin
      win_d = win_base + IdxW'(1);
    end else if (sel_d < win_base) begin
      win_d = win_base - IdxW'(1);
    end else begin
      win_d    = win_base;
      win_move = 1'b0;
    end

    res_d.buttons_down   = dmn_pkg::RawW'(MaxB'(pressed_n));
    res_d.select_event   = take_ok;
    res_d.cancel_event   = take_cancel;
    res_d.selected_index = sel_d;
    res_d.window_offset  = win_d;
    res_d.redraw         = take_cancel || take_zm || take_zp || win_move;
    res_d.beep           = beep;
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      menu_q      <= dmn_pkg::MenuCountRst;
      changed_q   <= '0;
      sel_q       <= '0;
      win_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        menu_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        changed_q   <= changed_d;
        sel_q       <= sel_d;
        win_q       <= win_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q <= raw_levels_i;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign buttons_down_o   = res_q.buttons_down;
  assign select_event_o   = res_q.select_event;
  assign cancel_event_o   = res_q.cancel_event;
  assign selected_index_o = res_q.selected_index;
  assign window_offset_o  = res_q.window_offset;
  assign redraw_o         = res_q.redraw;
  assign beep_o           = res_q.beep;

endmodule

/* rtl/dmn_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_checker - port-level checks for the menu navigator
// Watches the top level's channels; attached by bind below.
// ----------------------------------------------------------------------------
module dmn_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [dmn_pkg::RawW-1:0] buttons_down_o,
  input logic                     select_event_o,
  input logic                     cancel_event_o,
  input logic [dmn_pkg::IdxW-1:0] selected_index_o,
  input logic [dmn_pkg::IdxW-1:0] window_offset_o,
  input logic                     redraw_o,
  input logic                     beep_o
);

  // A stalled result item holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(buttons_down_o)
      && $stable(selected_index_o) && $stable(window_offset_o)
      && $stable(select_event_o) && $stable(cancel_event_o)
      && $stable(redraw_o) && $stable(beep_o))
    else $error("result item changed while stalled");

  // Input side only backs up behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // Cancel zeroes cursor and window, forces redraw, excludes select
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cancel_event_o |-> selected_index_o == '0
      && window_offset_o == '0 && redraw_o && !select_event_o)
    else $error("cancel item with inconsistent cursor");

  // Selection is always below the largest menu count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> selected_index_o != '1)
    else $error("selection out of range");

endmodule

bind debounced_menu_navigator_core dmn_checker u_dmn_checker (.*);

/* bench/dmn_nav_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_nav_checker - result checker for the debounced menu navigator
// Follows the config and input traffic, mirrors the debounce histories and the
// menu cursor, queues one predicted result per accepted item and compares each
// accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dmn_nav_checker
  import dmn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // observed config port
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_wdata_i,
  // observed input channel
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [RawW-1:0]   raw_levels_i,
  // observed result channel
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [RawW-1:0]   buttons_down_i,
  input  logic              select_event_i,
  input  logic              cancel_event_i,
  input  logic [IdxW-1:0]   selected_index_i,
  input  logic [IdxW-1:0]   window_offset_i,
  input  logic              redraw_i,
  input  logic              beep_i,
  // status for the testbench top
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       results_o
);

  localparam int MaxReports = 10;

  // Mirrored block state
  logic [HistoryBitsDef-1:0] lvl_hist [NumButtonsDef];
  logic [RawW-1:0]           pressed_q;
  logic [RawW-1:0]           changed_q;
  logic [IdxW-1:0]           sel_q;
  logic [IdxW-1:0]           win_q;
  logic [IdxW-1:0]           menu_cnt_q;

  result_t     predicted_nav_q [$];
  int unsigned err_cnt;
  int unsigned result_cnt;

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MaxReports) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v)
      flag_error($sformatf("result %0d: %s expected 0x%0h, got 0x%0h",
                           result_cnt, name, exp_v, act_v));
  endtask

  // One sample period: debounce, consume one press, clamp, scroll the window
  task automatic predict_nav_step(input logic [RawW-1:0] raw, output result_t res);
    logic was_down;
    int   sel;
    int   count;
    res = '0;
    for (int b = 0; b < NumButtonsDef; b++) begin
      was_down = pressed_q[b];
      lvl_hist[b] = {lvl_hist[b][HistoryBitsDef-2:0], raw[b]};
      if (lvl_hist[b] == '1) pressed_q[b] = 1'b0;
      else if (lvl_hist[b] == '0) pressed_q[b] = 1'b1;
      // press and release edges both mark the button as changed
      if (pressed_q[b] != was_down) changed_q[b] = 1'b1;
    end

    // priority: OK, Cancel, Z-minus, Z-plus
    sel = int'(sel_q);
    if (pressed_q[BtnOk] && changed_q[BtnOk]) begin
      changed_q[BtnOk] = 1'b0;
      res.select_event = 1'b1;
    end else if (pressed_q[BtnCancel] && changed_q[BtnCancel]) begin
      changed_q[BtnCancel] = 1'b0;
      sel = 0;
      win_q = '0;
      res.redraw = 1'b1;
      res.cancel_event = 1'b1;
    end else if (pressed_q[BtnZMinus] && changed_q[BtnZMinus]) begin
      changed_q[BtnZMinus] = 1'b0;
      sel++;
      res.redraw = 1'b1;
    end else if (pressed_q[BtnZPlus] && changed_q[BtnZPlus]) begin
      changed_q[BtnZPlus] = 1'b0;
      sel--;
      res.redraw = 1'b1;
    end

    // an empty menu counts as one entry; clamping also catches a shrunk menu
    count = (menu_cnt_q == '0) ? 1 : int'(menu_cnt_q);
    if (sel < 0) begin
      sel = 0;
      res.beep = 1'b1;
    end
    if (sel >= count) begin
      sel = count - 1;
      res.beep = 1'b1;
    end
    sel_q = sel[IdxW-1:0];

    // window trails the cursor by at most one row per item
    if (int'(sel_q) - int'(win_q) >= VisibleRowsDef) begin
      win_q++;
      res.redraw = 1'b1;
    end
    if (sel_q < win_q) begin
      win_q--;
      res.redraw = 1'b1;
    end

    res.buttons_down   = pressed_q;
    res.selected_index = sel_q;
    res.window_offset  = win_q;
  endtask

  // Watch both channels and the config port
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got;
    result_t want;
    if (!rst_ni) begin
      for (int b = 0; b < NumButtonsDef; b++) lvl_hist[b] = '1;
      pressed_q  = '0;
      changed_q  = '0;
      sel_q      = '0;
      win_q      = '0;
      menu_cnt_q = MenuCountRst;
      predicted_nav_q.delete();
      err_cnt    = 0;
      result_cnt = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
    end else begin
      if (cfg_we_i) menu_cnt_q = cfg_wdata_i;

      if (in_valid_i && in_ready_i) begin
        predict_nav_step(raw_levels_i, want);
        predicted_nav_q.push_back(want);
      end

      if (out_valid_i && out_ready_i) begin
        got.buttons_down   = buttons_down_i;
        got.select_event   = select_event_i;
        got.cancel_event   = cancel_event_i;
        got.selected_index = selected_index_i;
        got.window_offset  = window_offset_i;
        got.redraw         = redraw_i;
        got.beep           = beep_i;
        result_cnt++;
        if (predicted_nav_q.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected: %p",
                               result_cnt, got));
        end else begin
          want = predicted_nav_q.pop_front();
          check_field("buttons_down", 16'(want.buttons_down), 16'(got.buttons_down));
          check_field("select_event", 16'(want.select_event), 16'(got.select_event));
          check_field("cancel_event", 16'(want.cancel_event), 16'(got.cancel_event));
          check_field("selected_index", 16'(want.selected_index),
                      16'(got.selected_index));
          check_field("window_offset", 16'(want.window_offset),
                      16'(got.window_offset));
          check_field("redraw", 16'(want.redraw), 16'(got.redraw));
          check_field("beep", 16'(want.beep), 16'(got.beep));
        end
      end

      fail_count_o <= err_cnt;
      pending_o    <= predicted_nav_q.size();
      results_o    <= result_cnt;
    end
  end

endmodule

/* bench/debounced_menu_navigator_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_menu_navigator_core_tb - testbench top for the menu navigator
// Drives button sample items and menu sizes, throttles the result side, and
// leaves prediction and comparison to dmn_nav_checker. Directed presses are
// followed by random press/release gestures with contact bounce and noise
// across several menu sizes, including empty, single-entry and full menus.
// ----------------------------------------------------------------------------
module debounced_menu_navigator_core_tb;
  import dmn_pkg::*;

  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 10;
  localparam int PhaseItems    = 155;
  localparam int NumPhases     = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic            cfg_we     = 1'b0;
  logic [IdxW-1:0] cfg_wdata  = '0;
  logic            in_valid   = 1'b0;
  logic            in_ready;
  logic [RawW-1:0] raw_levels = '1;
  logic            out_valid;
  logic            out_ready  = 1'b0;
  logic [RawW-1:0] buttons_down;
  logic            select_event;
  logic            cancel_event;
  logic [IdxW-1:0] selected_index;
  logic [IdxW-1:0] window_offset;
  logic            redraw;
  logic            beep;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;

  // traffic shaping, shared with the receiver process
  int unsigned gap_pct      = 10;
  int unsigned stall_pct    = 10;
  logic        hold_off_req = 1'b0;
  int unsigned sent_cnt     = 0;
  int unsigned hold_cnt     = 0;
  int unsigned quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  debounced_menu_navigator_core i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .raw_levels_i     (raw_levels),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .buttons_down_o   (buttons_down),
    .select_event_o   (select_event),
    .cancel_event_o   (cancel_event),
    .selected_index_o (selected_index),
    .window_offset_o  (window_offset),
    .redraw_o         (redraw),
    .beep_o           (beep)
  );

  dmn_nav_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .raw_levels_i     (raw_levels),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .buttons_down_i   (buttons_down),
    .select_event_i   (select_event),
    .cancel_event_i   (cancel_event),
    .selected_index_i (selected_index),
    .window_offset_i  (window_offset),
    .redraw_i         (redraw),
    .beep_i           (beep),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .results_o        (results)
  );

  // Result side: random stalls, or one long hold-off on request
  initial begin : receiver
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        for (held = 0; held < HoldOffCycles; held++) @(posedge clk);
        hold_off_req = 1'b0;
        hold_cnt++;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sample item, with an occasional gap before it
  task automatic push_sample(input logic [RawW-1:0] lv);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_levels <= lv;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_menu_count(input logic [IdxW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Press and release, mostly one navigation button, with contact bounce
  task automatic run_gesture();
    logic [RawW-1:0] held_lv;
    int unsigned     pick;
    int unsigned     hold_len;
    held_lv = '1;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:    held_lv[BtnZMinus] = 1'b0;
      2, 3:    held_lv[BtnZPlus] = 1'b0;
      4:       held_lv[BtnOk] = 1'b0;
      5:       held_lv[BtnCancel] = 1'b0;
      6:       held_lv[4'($urandom_range(RawW - 1))] = 1'b0;
      default: held_lv = RawW'($urandom());
    endcase
    repeat ($urandom_range(0, 3)) push_sample(RawW'($urandom()));
    // short holds mostly leave a mixed history, which must not change state
    hold_len = ($urandom_range(3) == 0) ? $urandom_range(2, 7) : $urandom_range(8, 12);
    repeat (hold_len) push_sample(held_lv);
    repeat ($urandom_range(0, 2)) push_sample(RawW'($urandom()));
    repeat ($urandom_range(8, 12)) push_sample('1);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [IdxW-1:0] phase_menu [NumPhases];
    int unsigned     phase_end;
    phase_menu = '{8'd0, 8'd255, 8'd3, 8'd1, 8'd8, 8'd2, 8'd0, 8'd6};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: everything pressed at once drains OK, Cancel, Z-minus, Z-plus
    write_menu_count(8'd5);
    repeat (12) push_sample('0);
    // release of all buttons only sets the changed flags
    repeat (8) push_sample('1);
    push_sample(9'h0aa);
    push_sample(9'h155);
    push_sample('1);

    // random phases, each with its own menu size
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_menu_count((p == 6) ? IdxW'($urandom_range(1, 255)) : phase_menu[p]);
      gap_pct   = (p == 4) ? 0 : 10;
      stall_pct = (p == 4) ? 0 : 10;
      if (p == 2) hold_off_req = 1'b1;
      phase_end = sent_cnt + PhaseItems;
      while (sent_cnt < phase_end) begin
        if ($urandom_range(7) == 0) repeat ($urandom_range(1, 5)) push_sample(RawW'($urandom()));
        else run_gesture();
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d sample items and %0d results over %0d menu sizes,",
             sent_cnt, results, NumPhases + 1);
    $display("with bounce, noise, empty and shrinking menus and %0d output hold-off(s).",
             hold_cnt);
    if (pending != 0) $display("%0d predicted results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dmn_pkg.sv
rtl/dmn_debounce.sv
rtl/debounced_menu_navigator_core.sv
rtl/dmn_checker.sv
bench/dmn_nav_checker.sv
bench/debounced_menu_navigator_core_tb.sv
